// ----- src/gclp_pkg.sv -----
package gclp_pkg;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // magnitude ceiling of a value, 2^31
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;
  localparam logic [15:0] CODE_POS_MAX = 16'h7FFF;
  localparam logic [15:0] CODE_NEG_MIN = 16'h8000;
  localparam logic [31:0] CODE_MAG_LIM = 32'd32768;

  typedef enum logic [2:0] {
    PH_START,
    PH_CODE,
    PH_LETTER,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    LT_X,
    LT_Y,
    LT_Z,
    LT_C,
    LT_D,
    LT_E,
    LT_NONE
  } letter_t;

  // number scan state
  typedef struct packed {
    logic [31:0] acc;
    logic        neg;
    logic [2:0]  fc;
    logic        started;
    logic        stopped;
    logic        point;
  } num_t;

  // one command record
  typedef struct packed {
    logic               valid_res;
    logic               is_m_code;
    logic signed [15:0] code_number;
    logic               x_present;
    logic signed [31:0] x_value;
    logic               y_present;
    logic signed [31:0] y_value;
    logic               z_present;
    logic signed [31:0] z_value;
    logic signed [31:0] c_value;
    logic signed [31:0] d_value;
    logic signed [31:0] e_value;
  } rec_t;

  function automatic logic [19:0] pow10(input logic [2:0] k);
    logic [19:0] r;
    unique case (k)
      3'd0: r = 20'd1;
      3'd1: r = 20'd10;
      3'd2: r = 20'd100;
      3'd3: r = 20'd1000;
      3'd4: r = 20'd10000;
      3'd5: r = 20'd100000;
      3'd6: r = 20'd1000000;
      default: r = 20'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch >= CH_LA && ch <= CH_LZ) begin
      r = ch - CASE_GAP;
    end
    return r;
  endfunction

  function automatic letter_t letter_index(input logic [7:0] ch);
    letter_t r;
    r = LT_NONE;
    if (ch == CH_X) r = LT_X;
    if (ch == CH_Y) r = LT_Y;
    if (ch == CH_Z) r = LT_Z;
    if (ch == CH_C) r = LT_C;
    if (ch == CH_D) r = LT_D;
    if (ch == CH_E) r = LT_E;
    return r;
  endfunction

endpackage

// ----- src/gclp_numacc.sv -----
module gclp_numacc #(
  parameter int FRACTION_DIGITS = 3
) (
  input  gclp_pkg::num_t cur,
  input  logic [7:0]     ch,
  input  logic           allow_point,
  output gclp_pkg::num_t nxt
);
  import gclp_pkg::*;

  logic [35:0] grown;
  logic [31:0] acc_sat;
  logic        is_digit;
  logic        is_blank;
  logic        is_sign;

  // accumulate one decimal digit, saturating at the magnitude ceiling
  assign grown    = 36'(cur.acc) * 36'd10 + 36'(ch[3:0]);
  assign acc_sat  = (grown > 36'(MAG_CAP)) ? MAG_CAP : grown[31:0];
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign is_blank = (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

  // scan step
  always_comb begin
    nxt = cur;
    if (cur.stopped) begin
      nxt = cur;
    end else if (!cur.started && is_blank) begin
      nxt = cur;
    end else if (!cur.started && is_sign) begin
      nxt.neg     = (ch == CH_MINUS);
      nxt.started = 1'b1;
    end else begin
      nxt.started = 1'b1;
      if (is_digit) begin
        if (cur.point) begin
          if (cur.fc < 3'(FRACTION_DIGITS)) begin
            nxt.acc = acc_sat;
            nxt.fc  = cur.fc + 3'd1;
          end
        end else begin
          nxt.acc = acc_sat;
        end
      end else if (ch == CH_DOT && allow_point && !cur.point) begin
        nxt.point = 1'b1;
      end else begin
        nxt.stopped = 1'b1;
      end
    end
  end

endmodule

// ----- src/gclp_finish.sv -----
module gclp_finish #(
  parameter int FRACTION_DIGITS = 3
) (
  input  gclp_pkg::num_t     num,
  output logic signed [31:0] value,
  output logic signed [15:0] code
);
  import gclp_pkg::*;

  logic [19:0] scale;
  logic [51:0] prod;
  logic [31:0] mag;

  // scale to fixed point by the missing fraction digits, then saturate
  assign scale = pow10(3'(FRACTION_DIGITS) - num.fc);
  assign prod  = 52'(num.acc) * 52'(scale);
  assign mag   = (prod > 52'(MAG_CAP)) ? MAG_CAP : prod[31:0];

  // signed value
  always_comb begin
    if (num.neg) begin
      value = (mag == MAG_CAP) ? NEG_MIN : (32'd0 - mag);
    end else begin
      value = mag[31] ? POS_MAX : mag;
    end
  end

  // signed code, 16-bit saturation
  always_comb begin
    if (num.neg) begin
      code = (num.acc >= CODE_MAG_LIM) ? CODE_NEG_MIN : (16'd0 - num.acc[15:0]);
    end else begin
      code = (num.acc > 32'(CODE_POS_MAX)) ? CODE_POS_MAX : num.acc[15:0];
    end
  end

endmodule

// ----- src/gclp_parse.sv -----
module gclp_parse #(
  parameter int MAX_TOKENS      = 6,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  output gclp_pkg::rec_t   rec,
  output logic             emit
);
  import gclp_pkg::*;

  phase_t      phase, phase_next;
  logic        line_ok, line_ok_next;
  logic        is_m_flag, is_m_flag_next;
  logic [15:0] code_accum, code_accum_next;
  num_t        num, num_next;
  letter_t     letter, letter_next;
  logic [2:0]  token_count, token_count_next;
  logic [31:0] axis_values [6];
  logic [31:0] axis_values_next [6];
  logic [2:0]  axis_present, axis_present_next;

  logic [7:0]         uc;
  logic               is_lf;
  logic               is_cr;
  logic               is_sp;
  num_t               num_fed;
  logic signed [31:0] fin_value;
  logic signed [15:0] fin_code;
  logic [31:0]        axis_fin [6];
  logic [2:0]         present_fin;
  logic [15:0]        code_fin;
  logic               tok_open;

  assign uc    = to_upper(ch);
  assign is_lf = (ch == CH_LF);
  assign is_cr = (uc == CH_CR);
  assign is_sp = (uc == CH_SP);
  assign emit  = step && is_cr;

  gclp_numacc #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_numacc (
    .cur        (num),
    .ch         (uc),
    .allow_point(phase == PH_VALUE),
    .nxt        (num_fed)
  );

  gclp_finish #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_finish (
    .num  (num),
    .value(fin_value),
    .code (fin_code)
  );

  // record as it stands if the line ends now
  assign tok_open = (phase == PH_VALUE);
  assign code_fin = (phase == PH_CODE) ? fin_code : code_accum;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      axis_fin[i] = (tok_open && letter == letter_t'(i)) ? fin_value : axis_values[i];
    end
    for (int i = 0; i < 3; i++) begin
      present_fin[i] = axis_present[i] || (tok_open && letter == letter_t'(i));
    end
  end

  always_comb begin
    rec = '0;
    if (line_ok) begin
      rec.valid_res   = 1'b1;
      rec.is_m_code   = is_m_flag;
      rec.code_number = code_fin;
      rec.x_present   = present_fin[0];
      rec.x_value     = axis_fin[0];
      rec.y_present   = present_fin[1];
      rec.y_value     = axis_fin[1];
      rec.z_present   = present_fin[2];
      rec.z_value     = axis_fin[2];
      rec.c_value     = axis_fin[3];
      rec.d_value     = axis_fin[4];
      rec.e_value     = axis_fin[5];
    end
  end

  // next state
  always_comb begin
    phase_next        = phase;
    line_ok_next      = line_ok;
    is_m_flag_next    = is_m_flag;
    code_accum_next   = code_accum;
    num_next          = num;
    letter_next       = letter;
    token_count_next  = token_count;
    axis_present_next = axis_present;
    for (int i = 0; i < 6; i++) begin
      axis_values_next[i] = axis_values[i];
    end
    if (step && !is_lf) begin
      if (is_cr) begin
        phase_next        = PH_START;
        line_ok_next      = 1'b0;
        is_m_flag_next    = 1'b0;
        code_accum_next   = '0;
        num_next          = '0;
        letter_next       = LT_NONE;
        token_count_next  = '0;
        axis_present_next = '0;
        for (int i = 0; i < 6; i++) begin
          axis_values_next[i] = '0;
        end
      end else begin
        unique case (phase)
          PH_START: begin
            if (uc == CH_G || uc == CH_M) begin
              line_ok_next   = 1'b1;
              is_m_flag_next = (uc == CH_M);
              num_next       = '0;
              phase_next     = PH_CODE;
            end else begin
              line_ok_next = 1'b0;
              phase_next   = PH_SKIP;
            end
          end
          PH_CODE: begin
            if (is_sp) begin
              code_accum_next = fin_code;
              phase_next      = PH_LETTER;
            end else begin
              num_next = num_fed;
            end
          end
          PH_LETTER: begin
            if (is_sp) begin
              phase_next = PH_SKIP;
            end else begin
              letter_next = letter_index(uc);
              num_next    = '0;
              phase_next  = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (is_sp) begin
              // close the token
              if (letter != LT_NONE) begin
                axis_values_next[letter] = fin_value;
              end
              if (letter == LT_X || letter == LT_Y || letter == LT_Z) begin
                axis_present_next[letter[1:0]] = 1'b1;
              end
              token_count_next = token_count + 3'd1;
              if (letter == LT_NONE || (token_count + 3'd1) >= 3'(MAX_TOKENS)) begin
                phase_next = PH_SKIP;
              end else begin
                phase_next = PH_LETTER;
              end
              letter_next = LT_NONE;
            end else begin
              num_next = num_fed;
            end
          end
          PH_SKIP: begin
            phase_next = PH_SKIP;
          end
          default: begin
            phase_next = PH_SKIP;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      line_ok      <= 1'b0;
      is_m_flag    <= 1'b0;
      code_accum   <= '0;
      num          <= '0;
      letter       <= LT_NONE;
      token_count  <= '0;
      axis_present <= '0;
      for (int i = 0; i < 6; i++) begin
        axis_values[i] <= '0;
      end
    end else begin
      phase        <= phase_next;
      line_ok      <= line_ok_next;
      is_m_flag    <= is_m_flag_next;
      code_accum   <= code_accum_next;
      num          <= num_next;
      letter       <= letter_next;
      token_count  <= token_count_next;
      axis_present <= axis_present_next;
      for (int i = 0; i < 6; i++) begin
        axis_values[i] <= axis_values_next[i];
      end
    end
  end

  // a fresh line carries nothing over
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> !line_ok && token_count == 3'd0 && axis_present == 3'd0)
    else $error("line start with stale line state");

  // token limit respected
  a_token_limit: assert property (@(posedge clk) disable iff (rst)
    token_count <= 3'(MAX_TOKENS))
    else $error("token count beyond limit");

  // fraction digits never exceed the fixed-point precision
  a_frac_limit: assert property (@(posedge clk) disable iff (rst)
    num.fc <= 3'(FRACTION_DIGITS))
    else $error("fraction digit count beyond precision");

  // every line end returns to line start
  a_emit_restart: assert property (@(posedge clk) disable iff (rst)
    emit |=> phase == PH_START)
    else $error("line end did not restart the parser");

endmodule

// ----- src/gcode_line_parser_top.sv -----
// path: a line-end character passes from the input register through the parse logic
// into the result register, and waits in the input register while a result is stalled
// throughput: one character per cycle; characters other than line end are taken
// while a result waits, a line end waits only behind a result that is still stalled
// reset: clears the parser to line start, all stored values to zero, and both
// register stages to empty
module gcode_line_parser_top #(
  parameter int MAX_TOKENS      = 6,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic               is_m_code,
  output logic signed [15:0] code_number,
  output logic               x_present,
  output logic signed [31:0] x_value,
  output logic               y_present,
  output logic signed [31:0] y_value,
  output logic               z_present,
  output logic signed [31:0] z_value,
  output logic signed [31:0] c_value,
  output logic signed [31:0] d_value,
  output logic signed [31:0] e_value
);
  import gclp_pkg::*;

  logic       ir_valid;
  logic [7:0] ir_char;
  rec_t       out_rec;
  rec_t       rec;
  logic       emit;
  logic       step;
  logic       out_free;
  logic       in_take;

  // flow control
  assign out_free = !out_valid || !out_stall;
  assign step     = ir_valid && ((ir_char != CH_CR) || out_free);
  assign in_stall = ir_valid && !step;
  assign in_take  = in_valid && !in_stall;

  gclp_parse #(
    .MAX_TOKENS     (MAX_TOKENS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_parse (
    .clk (clk),
    .rst (rst),
    .step(step),
    .ch  (ir_char),
    .rec (rec),
    .emit(emit)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else begin
      ir_valid <= in_take || (ir_valid && !step);
      if (in_take) begin
        ir_char <= char_code;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_rec   <= rec;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign valid_res   = out_rec.valid_res;
  assign is_m_code   = out_rec.is_m_code;
  assign code_number = out_rec.code_number;
  assign x_present   = out_rec.x_present;
  assign x_value     = out_rec.x_value;
  assign y_present   = out_rec.y_present;
  assign y_value     = out_rec.y_value;
  assign z_present   = out_rec.z_present;
  assign z_value     = out_rec.z_value;
  assign c_value     = out_rec.c_value;
  assign d_value     = out_rec.d_value;
  assign e_value     = out_rec.e_value;

  // an invalid record carries only zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> !is_m_code && code_number == 16'sd0 &&
      !x_present && !y_present && !z_present && x_value == 32'sd0 &&
      y_value == 32'sd0 && z_value == 32'sd0 && c_value == 32'sd0 &&
      d_value == 32'sd0 && e_value == 32'sd0)
    else $error("invalid record with nonzero fields");

  // input holds back only for a line end behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ir_valid && ir_char == CH_CR && out_valid && out_stall)
    else $error("input stalled without cause");

  // a new record never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !(out_valid && out_stall))
    else $error("record overwritten while stalled");

endmodule

// ----- tb/tb_gcode_line_parser_top.sv -----
`timescale 1ns / 100ps

module tb_gcode_line_parser_top;
  import gclp_pkg::*;

  localparam int MAX_TOKENS      = 6;
  localparam int FRACTION_DIGITS = 3;
  localparam int RANDOM_CHARS    = 730;
  localparam int MIN_LINES       = 20;
  localparam int QUIET_FROM      = 700;
  localparam int QUIET_TO        = 1000;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 10;
  localparam int MAX_REPORTS     = 10;
  localparam logic [7:0]  CH_A      = 8'h41;
  localparam logic [63:0] VALUE_CAP = 64'h8000_0000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_code = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               valid_res;
  logic               is_m_code;
  logic signed [15:0] code_number;
  logic               x_present;
  logic signed [31:0] x_value;
  logic               y_present;
  logic signed [31:0] y_value;
  logic               z_present;
  logic signed [31:0] z_value;
  logic signed [31:0] c_value;
  logic signed [31:0] d_value;
  logic signed [31:0] e_value;

  gcode_line_parser_top #(
    .MAX_TOKENS      (MAX_TOKENS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (valid_res),
    .is_m_code   (is_m_code),
    .code_number (code_number),
    .x_present   (x_present),
    .x_value     (x_value),
    .y_present   (y_present),
    .y_value     (y_value),
    .z_present   (z_present),
    .z_value     (z_value),
    .c_value     (c_value),
    .d_value     (d_value),
    .e_value     (e_value)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // characters waiting to be sent and records waiting to come back
  logic [7:0] char_queue[$];
  rec_t       expected_records[$];

  bit in_fire;
  int chars_sent;
  int chars_made;
  int lines_made;
  int line_noise;
  int mismatch_count;

  // parser state mirrored by the predictor
  phase_t      parse_phase;
  letter_t     cur_letter;
  bit          line_good;
  bit          m_line;
  logic [15:0] code_val;
  logic [63:0] num_mag;
  bit          num_neg;
  bit          num_on;
  bit          num_off;
  bit          dot_seen;
  int          frac_digits;
  int          token_total;
  logic [31:0] axis_val[6];
  logic [2:0]  axis_given;

  function automatic logic [63:0] cap_mag(input logic [63:0] v);
    return (v > VALUE_CAP) ? VALUE_CAP : v;
  endfunction

  task automatic clear_number();
    num_mag     = '0;
    num_neg     = 1'b0;
    frac_digits = 0;
    num_on      = 1'b0;
    num_off     = 1'b0;
    dot_seen    = 1'b0;
  endtask

  task automatic clear_line();
    parse_phase = PH_START;
    line_good   = 1'b0;
    m_line      = 1'b0;
    code_val    = '0;
    cur_letter  = LT_NONE;
    token_total = 0;
    axis_given  = '0;
    for (int i = 0; i < 6; i++) axis_val[i] = '0;
    clear_number();
  endtask

  // one character of a number: blanks, sign, digits, at most one point
  task automatic scan_number_char(input logic [7:0] ch, input bit allow_point);
    if (num_off) begin
      // rest of the token is ignored
    end else if (!num_on && (ch == CH_TAB || ch == CH_VT || ch == CH_FF)) begin
      // leading blank skipped
    end else if (!num_on && (ch == CH_PLUS || ch == CH_MINUS)) begin
      num_neg = (ch == CH_MINUS);
      num_on  = 1'b1;
    end else begin
      num_on = 1'b1;
      if (ch >= CH_0 && ch <= CH_9) begin
        // extra fraction digits are dropped
        if (!dot_seen || frac_digits < FRACTION_DIGITS) begin
          num_mag = cap_mag(num_mag * 10 + (ch - CH_0));
          if (dot_seen) frac_digits++;
        end
      end else if (ch == CH_DOT && allow_point && !dot_seen) begin
        dot_seen = 1'b1;
      end else begin
        num_off = 1'b1;
      end
    end
  endtask

  // code number, saturated to 16 bits
  task automatic finish_code();
    if (num_neg) begin
      code_val = (num_mag >= 64'd32768) ? CODE_NEG_MIN : 16'h0000 - num_mag[15:0];
    end else begin
      code_val = (num_mag > 64'd32767) ? CODE_POS_MAX : num_mag[15:0];
    end
  endtask

  // value in thousandths, saturated to 32 bits
  function automatic logic [31:0] scaled_value();
    logic [63:0] m;
    logic [31:0] r;
    m = num_mag;
    for (int k = frac_digits; k < FRACTION_DIGITS; k++) m = cap_mag(m * 10);
    if (num_neg) begin
      r = (m >= VALUE_CAP) ? NEG_MIN : 32'h0 - m[31:0];
    end else begin
      r = (m > 64'h7FFF_FFFF) ? POS_MAX : m[31:0];
    end
    return r;
  endfunction

  task automatic finish_token();
    logic [31:0] v;
    v = scaled_value();
    if (cur_letter != LT_NONE) begin
      axis_val[int'(cur_letter)] = v;
      if (cur_letter == LT_X || cur_letter == LT_Y || cur_letter == LT_Z) begin
        axis_given[int'(cur_letter)] = 1'b1;
      end
    end
    token_total++;
    if (cur_letter == LT_NONE || token_total >= MAX_TOKENS) begin
      parse_phase = PH_SKIP;
    end else begin
      parse_phase = PH_LETTER;
    end
    cur_letter = LT_NONE;
  endtask

  function automatic letter_t axis_of(input logic [7:0] ch);
    letter_t r;
    case (ch)
      CH_X:    r = LT_X;
      CH_Y:    r = LT_Y;
      CH_Z:    r = LT_Z;
      CH_C:    r = LT_C;
      CH_D:    r = LT_D;
      CH_E:    r = LT_E;
      default: r = LT_NONE;
    endcase
    return r;
  endfunction

  // advance the parser by one accepted character, queue a record at line end
  task automatic predict_char(input logic [7:0] raw);
    logic [7:0] ch;
    rec_t       rec;
    ch = raw;
    if (ch >= CH_LA && ch <= CH_LZ) ch = ch - CASE_GAP;
    if (raw == CH_LF) begin
      // line feeds are dropped
    end else if (ch == CH_CR) begin
      if (parse_phase == PH_CODE) begin
        finish_code();
      end else if (parse_phase == PH_VALUE) begin
        finish_token();
      end
      rec = '0;
      if (line_good) begin
        rec.valid_res   = 1'b1;
        rec.is_m_code   = m_line;
        rec.code_number = code_val;
        rec.x_present   = axis_given[0];
        rec.x_value     = axis_val[0];
        rec.y_present   = axis_given[1];
        rec.y_value     = axis_val[1];
        rec.z_present   = axis_given[2];
        rec.z_value     = axis_val[2];
        rec.c_value     = axis_val[3];
        rec.d_value     = axis_val[4];
        rec.e_value     = axis_val[5];
      end
      expected_records.push_back(rec);
      clear_line();
    end else begin
      case (parse_phase)
        PH_START: begin
          if (ch == CH_G || ch == CH_M) begin
            line_good = 1'b1;
            m_line    = (ch == CH_M);
            clear_number();
            parse_phase = PH_CODE;
          end else begin
            line_good   = 1'b0;
            parse_phase = PH_SKIP;
          end
        end
        PH_CODE: begin
          if (ch == CH_SP) begin
            finish_code();
            parse_phase = PH_LETTER;
          end else begin
            scan_number_char(ch, 1'b0);
          end
        end
        PH_LETTER: begin
          if (ch == CH_SP) begin
            parse_phase = PH_SKIP;
          end else begin
            cur_letter = axis_of(ch);
            clear_number();
            parse_phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (ch == CH_SP) begin
            finish_token();
          end else begin
            scan_number_char(ch, 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    rec_t want;
    if (rst) begin
      in_fire = 1'b0;
      clear_line();
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        predict_char(char_code);
        chars_sent++;
      end
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("record arrived with no line end pending");
          end
        end else begin
          want = expected_records.pop_front();
          check_field("valid_res",   valid_res,   want.valid_res);
          check_field("is_m_code",   is_m_code,   want.is_m_code);
          check_field("code_number", code_number, want.code_number);
          check_field("x_present",   x_present,   want.x_present);
          check_field("x_value",     x_value,     want.x_value);
          check_field("y_present",   y_present,   want.y_present);
          check_field("y_value",     y_value,     want.y_value);
          check_field("z_present",   z_present,   want.z_present);
          check_field("z_value",     z_value,     want.z_value);
          check_field("c_value",     c_value,     want.c_value);
          check_field("d_value",     d_value,     want.d_value);
          check_field("e_value",     e_value,     want.e_value);
        end
      end
    end
  end

  // driver: next character after each transfer, random gaps and output stalls
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (chars_sent >= QUIET_FROM && chars_sent < QUIET_TO) ? 0 : 20;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
      if (!in_valid || in_fire) begin
        if (char_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          char_code <= char_queue.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    char_queue.push_back(c);
    chars_made++;
  endtask

  // broken lines get stray bytes and line feeds mixed in
  task automatic add_char(input logic [7:0] c);
    if ($urandom_range(99) < line_noise) begin
      push_char(($urandom_range(3) == 0) ? CH_LF : 8'($urandom_range(255)));
    end
    push_char(c);
  endtask

  task automatic push_line(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_char(CH_CR);
  endtask

  function automatic logic [7:0] pick_case(input logic [7:0] c);
    return ($urandom_range(3) == 0) ? c + CASE_GAP : c;
  endfunction

  function automatic logic [7:0] token_letter();
    logic [7:0] r;
    case ($urandom_range(12))
      0, 6:    r = CH_X;
      1, 7:    r = CH_Y;
      2, 8:    r = CH_Z;
      3, 9:    r = CH_C;
      4, 10:   r = CH_D;
      5, 11:   r = CH_E;
      default: r = CH_A + 8'($urandom_range(25));
    endcase
    return r;
  endfunction

  task automatic push_number(input bit allow_point);
    int n_int;
    if ($urandom_range(19) == 0) add_char(CH_TAB);
    case ($urandom_range(5))
      0:       add_char(CH_MINUS);
      1:       add_char(CH_PLUS);
      default: begin
      end
    endcase
    // mostly short numbers, now and then long enough to saturate
    n_int = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 5);
    repeat (n_int) add_char(CH_0 + 8'($urandom_range(9)));
    if (allow_point && $urandom_range(2) == 0) begin
      add_char(CH_DOT);
      repeat ($urandom_range(0, 5)) add_char(CH_0 + 8'($urandom_range(9)));
    end
  endtask

  // one line: mostly well formed commands, some broken, a few pure noise
  task automatic push_random_line();
    int kind;
    int n_tok;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 20)) push_char(8'($urandom_range(255)));
    end else begin
      line_noise = (kind < 25) ? 4 : 0;
      add_char(pick_case(($urandom_range(1) == 1) ? CH_G : CH_M));
      push_number(1'b0);
      n_tok = $urandom_range(0, 8);
      for (int t = 0; t < n_tok; t++) begin
        add_char(CH_SP);
        if ($urandom_range(49) == 0) add_char(CH_SP);
        add_char(pick_case(token_letter()));
        push_number(1'b1);
      end
    end
    push_char(CH_CR);
    if ($urandom_range(9) == 0) push_char(CH_LF);
    lines_made++;
  endtask

  // hold the sender until every line end has produced its record
  task automatic settle_all();
    while (char_queue.size() != 0 || in_valid || expected_records.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // stimulus and end of test
  initial begin
    int wait_cycles;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed lines
    line_noise = 0;
    push_line("G1 X10.5 Y-2.25 Z+0.001 C1 D2 E3");
    push_line("m104 x1 y-.5 e7");
    push_line("G0 X1 Y2 Z3 C4 D5 E6 X7");
    push_line("G1 X Y Z");
    push_line("G1 Z");
    push_line("G1 X5  Y6");
    push_line("G1 X5 Q7 Y6");
    push_line("G1 X1 X-2");
    push_line("T5 X1");
    push_line(" G1");
    push_line("");
    push_line("G");
    push_line("G99999 X1");
    push_line("M-40000");
    push_line("G-32768 Y1");
    push_line("G1 X99999999 Y-2147483.648 Z2147483.647 C-9999999.9999 D1.23456");
    push_line("G1 X2147483.648 Y-2147483.649");
    push_line("G1 X\t-1.5 Y1.2.3 Z12abc C\v\f+7 D+-5 E.");
    push_line("G12.5 X1");
    push_line("G1 X1\n2");
    push_char(CH_G);
    push_char(CH_0 + 8'd1);
    push_char(CH_SP);
    push_char(CH_X);
    push_char(8'hFF);
    push_char(8'h80);
    push_char(CH_CR);
    push_char(CH_LF);
    settle_all();

    // random lines in two batches with a full drain between them
    chars_made = 0;
    lines_made = 0;
    while (chars_made < RANDOM_CHARS / 2) push_random_line();
    settle_all();
    while (chars_made < RANDOM_CHARS || lines_made < MIN_LINES) push_random_line();

    // drain and let the pipeline go quiet
    while (char_queue.size() != 0 || in_valid) @(posedge clk);
    wait_cycles = 0;
    while (expected_records.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (expected_records.size() != 0) begin
      mismatch_count++;
      $display("%0d records never arrived", expected_records.size());
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
